// ===== rtl/hgba_pkg.sv =====
`timescale 1ns / 1ps

package hgba_pkg;

   // Grid size defaults.
   localparam int ROWS_DEFAULT = 16;
   localparam int COLS_DEFAULT = 16;

   // Field widths.
   localparam int FUNC_W = 2;
   localparam int IDX_W  = 4;
   localparam int VAL_W  = 14;
   localparam int PASS_W = 8;

   // Operation codes.
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RUN   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   // Register map.
   localparam int                    CSR_ADDR_W     = 2;
   localparam int                    CSR_DATA_W     = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_PASS_COUNT = 2'd0;
   localparam logic [PASS_W-1:0]     PASS_RESET     = 8'd2;

   // Stencil arithmetic: a column sum of three cells, a window sum of nine.
   localparam int VSUM_W = VAL_W + 2;
   localparam int SUM_W  = VAL_W + 4;

   // Division by 9 as a multiplication by ceil(2^21 / 9). The error term is
   // small enough that the quotient is exact for every sum below 2^18.
   localparam int               DIV_MULT_W = 18;
   localparam logic [DIV_MULT_W-1:0] DIV_MULT = 18'd233017;
   localparam int               DIV_SHIFT  = 21;
   localparam int               PROD_W     = SUM_W + DIV_MULT_W;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic host_we;    // write the current grid bank at the host address
      logic rd_en;      // read the current grid bank
      logic sweep;      // this cycle belongs to a smoothing pass
      logic slot_first; // upper neighbour row of the column
      logic slot_last;  // lower neighbour row of the column
      logic col_first;  // first column of a grid row
      logic emit;       // a finished window sum follows this read
      logic cur_bank;   // bank that holds the current grid
   } cmd_type;

   typedef struct packed {
      logic pipe_empty; // no pass result is still in flight
   } status_type;

endpackage

// ===== rtl/hgba_ram.sv =====
`timescale 1ns / 1ps

module hgba_ram #(
   parameter int WIDTH = hgba_pkg::VAL_W,
   parameter int DEPTH = hgba_pkg::ROWS_DEFAULT * hgba_pkg::COLS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/hgba_datapath.sv =====
`timescale 1ns / 1ps

module hgba_datapath #(
   parameter int ROWS = hgba_pkg::ROWS_DEFAULT,
   parameter int COLS = hgba_pkg::COLS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hgba_pkg::cmd_type                cmd,
   input  logic [$clog2(ROWS*COLS)-1:0]     rd_addr,
   input  logic [$clog2(ROWS*COLS)-1:0]     host_waddr,
   input  logic [hgba_pkg::VAL_W-1:0]       host_wdata,
   input  logic [$clog2(ROWS*COLS)-1:0]     pass_waddr,
   output logic [hgba_pkg::VAL_W-1:0]       rd_data,
   output hgba_pkg::status_type             status
);

   localparam int DEPTH  = ROWS * COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int VAL_W  = hgba_pkg::VAL_W;
   localparam int VSUM_W = hgba_pkg::VSUM_W;
   localparam int SUM_W  = hgba_pkg::SUM_W;
   localparam int PROD_W = hgba_pkg::PROD_W;

   // Two banks: one holds the current grid, the other collects a pass.
   logic [1:0]             bank_we;
   logic [ADDR_W-1:0]      bank_waddr [2];
   logic [VAL_W-1:0]       bank_wdata [2];
   logic [VAL_W-1:0]       bank_rdata [2];

   hgba_pkg::cmd_type      s1_ff;
   logic [ADDR_W-1:0]      s1_waddr_ff;
   logic [VSUM_W-1:0]      acc_ff, acc_in;
   logic [VSUM_W-1:0]      col0_ff, col0_in;
   logic [VSUM_W-1:0]      col1_ff, col1_in;
   logic [VSUM_W-1:0]      rd_val;
   logic [VSUM_W-1:0]      vsum;
   logic                   s2_emit_ff;
   logic [SUM_W-1:0]       s2_total_ff, s2_total_in;
   logic [ADDR_W-1:0]      s2_waddr_ff;
   logic                   s3_emit_ff;
   logic [PROD_W-1:0]      s3_prod_ff, s3_prod_in;
   logic [ADDR_W-1:0]      s3_waddr_ff;
   logic [VAL_W-1:0]       quotient;

   for (genvar b = 0; b < 2; b++) begin : g_bank
      hgba_ram #(
         .WIDTH (VAL_W),
         .DEPTH (DEPTH)
      ) u_ram (
         .clock (clock),
         .we    (bank_we[b]),
         .waddr (bank_waddr[b]),
         .wdata (bank_wdata[b]),
         .re    (cmd.rd_en),
         .raddr (rd_addr),
         .rdata (bank_rdata[b])
      );
   end

   assign quotient = s3_prod_ff[hgba_pkg::DIV_SHIFT +: VAL_W];

   // Pass results go to the spare bank, host writes and the reset clear to the
   // current one; the two never coincide.
   always_comb begin
      for (int b = 0; b < 2; b++) begin
         if (s3_emit_ff && (cmd.cur_bank != 1'(b))) begin
            bank_we[b]    = 1'b1;
            bank_waddr[b] = s3_waddr_ff;
            bank_wdata[b] = quotient;
         end else begin
            bank_we[b]    = cmd.host_we && (cmd.cur_bank == 1'(b));
            bank_waddr[b] = host_waddr;
            bank_wdata[b] = host_wdata;
         end
      end
   end

   assign rd_data = bank_rdata[cmd.cur_bank];

   always_comb begin
      rd_val      = s1_ff.rd_en ? VSUM_W'(rd_data) : '0;
      vsum        = (s1_ff.slot_first ? '0 : acc_ff) + rd_val;
      acc_in      = acc_ff;
      col0_in     = col0_ff;
      col1_in     = col1_ff;
      if (s1_ff.sweep) begin
         acc_in = vsum;
         if (s1_ff.slot_last) begin
            col0_in = s1_ff.col_first ? '0 : col1_ff;
            col1_in = vsum;
         end
      end
      s2_total_in = SUM_W'(col0_ff) + SUM_W'(col1_ff) + SUM_W'(vsum);
      s3_prod_in  = PROD_W'(s2_total_ff) * PROD_W'(hgba_pkg::DIV_MULT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff      <= '0;
         s2_emit_ff <= 1'b0;
         s3_emit_ff <= 1'b0;
      end else begin
         s1_ff      <= cmd;
         s2_emit_ff <= s1_ff.sweep && s1_ff.slot_last && s1_ff.emit;
         s3_emit_ff <= s2_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_waddr_ff <= pass_waddr;
      acc_ff      <= acc_in;
      col0_ff     <= col0_in;
      col1_ff     <= col1_in;
      s2_total_ff <= s2_total_in;
      s2_waddr_ff <= s1_waddr_ff;
      s3_prod_ff  <= s3_prod_in;
      s3_waddr_ff <= s2_waddr_ff;
   end

   assign status.pipe_empty = !s1_ff.sweep && !s2_emit_ff && !s3_emit_ff;

endmodule

// ===== rtl/hgba_controller.sv =====
`timescale 1ns / 1ps

module hgba_controller #(
   parameter int ROWS = hgba_pkg::ROWS_DEFAULT,
   parameter int COLS = hgba_pkg::COLS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hgba_pkg::FUNC_W-1:0]      req_func,
   input  logic [hgba_pkg::IDX_W-1:0]       req_row,
   input  logic [hgba_pkg::IDX_W-1:0]       req_col,
   input  logic [hgba_pkg::VAL_W-1:0]       req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hgba_pkg::FUNC_W-1:0]      rsp_done_op,
   output logic [hgba_pkg::VAL_W-1:0]       rsp_cell_value,
   input  logic [hgba_pkg::PASS_W-1:0]      pass_count,
   output hgba_pkg::cmd_type                cmd,
   output logic [$clog2(ROWS*COLS)-1:0]     rd_addr,
   output logic [$clog2(ROWS*COLS)-1:0]     host_waddr,
   output logic [hgba_pkg::VAL_W-1:0]       host_wdata,
   output logic [$clog2(ROWS*COLS)-1:0]     pass_waddr,
   input  logic [hgba_pkg::VAL_W-1:0]       rd_data,
   input  hgba_pkg::status_type             status
);

   localparam int DEPTH  = ROWS * COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int EXT_W  = ADDR_W + 2;
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_W  = $clog2(COLS + 1);
   localparam int FUNC_W = hgba_pkg::FUNC_W;
   localparam int VAL_W  = hgba_pkg::VAL_W;
   localparam int PASS_W = hgba_pkg::PASS_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_PASS  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;

   localparam logic [1:0] SLOT_FIRST = 2'd0;
   localparam logic [1:0] SLOT_LAST  = 2'd2;

   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  COL_END   = COL_W'(COLS);
   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);

   logic [2:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [1:0]         slot_ff, slot_in;
   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [PASS_W-1:0]  passes_ff, passes_in;
   logic               bank_ff, bank_in;
   logic               hit_ff, hit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FUNC_W-1:0]  done_op_ff, done_op_in;
   logic [VAL_W-1:0]   cell_value_ff, cell_value_in;

   logic               accept;
   logic               host_inside;
   logic [ADDR_W-1:0]  host_addr;
   logic [EXT_W-1:0]   sweep_addr;
   logic               slot_first;
   logic               slot_last;
   logic               col_end;

   assign req_ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept      = req_valid && req_ready;
   assign host_inside = (int'(req_row) < ROWS) && (int'(req_col) < COLS);
   assign host_addr   = ADDR_W'(int'(req_row) * COLS + int'(req_col));

   assign slot_first  = (slot_ff == SLOT_FIRST);
   assign slot_last   = (slot_ff == SLOT_LAST);
   assign col_end     = (col_ff == COL_END);

   // Neighbour address: the row above, this row or the row below, at the
   // column being loaded into the window.
   always_comb begin
      sweep_addr = EXT_W'(base_ff) + EXT_W'(col_ff);
      if (slot_last) begin
         sweep_addr = sweep_addr + EXT_W'(COLS);
      end else if (slot_first) begin
         sweep_addr = sweep_addr - EXT_W'(COLS);
      end
   end

   assign pass_waddr = ADDR_W'(EXT_W'(base_ff) + EXT_W'(col_ff) - EXT_W'(1));

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      slot_in       = slot_ff;
      base_in       = base_ff;
      passes_in     = passes_ff;
      bank_in       = bank_ff;
      hit_in        = hit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      done_op_in    = done_op_ff;
      cell_value_in = cell_value_ff;

      cmd           = '0;
      cmd.cur_bank  = bank_ff;
      rd_addr       = host_addr;
      host_waddr    = host_addr;
      host_wdata    = req_value;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.host_we = 1'b1;
            host_waddr  = clr_ff;
            host_wdata  = '0;
            if (clr_ff == ADDR_LAST) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_func)
                  hgba_pkg::FUNC_WRITE: begin
                     cmd.host_we   = host_inside;
                     rsp_valid_in  = 1'b1;
                     done_op_in    = req_func;
                     cell_value_in = '0;
                  end
                  hgba_pkg::FUNC_RUN: begin
                     if (pass_count == '0) begin
                        rsp_valid_in  = 1'b1;
                        done_op_in    = req_func;
                        cell_value_in = '0;
                     end else begin
                        passes_in = pass_count;
                        row_in    = '0;
                        col_in    = '0;
                        slot_in   = SLOT_FIRST;
                        base_in   = '0;
                        state_in  = ST_PASS;
                     end
                  end
                  hgba_pkg::FUNC_READ: begin
                     cmd.rd_en = 1'b1;
                     hit_in    = host_inside;
                     state_in  = ST_READ;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     done_op_in    = req_func;
                     cell_value_in = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            done_op_in    = hgba_pkg::FUNC_READ;
            cell_value_in = hit_ff ? rd_data : '0;
            state_in      = ST_IDLE;
         end
         ST_PASS: begin
            // Reads outside the grid are suppressed and count as zero.
            cmd.sweep      = 1'b1;
            cmd.rd_en      = !col_end
                             && !(slot_first && (row_ff == '0))
                             && !(slot_last && (row_ff == ROW_LAST));
            cmd.slot_first = slot_first;
            cmd.slot_last  = slot_last;
            cmd.col_first  = (col_ff == '0);
            cmd.emit       = slot_last && (col_ff != '0);
            rd_addr        = ADDR_W'(sweep_addr);
            if (!slot_last) begin
               slot_in = slot_ff + 2'd1;
            end else begin
               slot_in = SLOT_FIRST;
               if (!col_end) begin
                  col_in = col_ff + COL_W'(1);
               end else begin
                  col_in = '0;
                  if (row_ff == ROW_LAST) begin
                     row_in   = '0;
                     base_in  = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     row_in  = row_ff + ROW_W'(1);
                     base_in = base_ff + ADDR_W'(COLS);
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (status.pipe_empty) begin
               bank_in   = !bank_ff;
               passes_in = passes_ff - PASS_W'(1);
               if (passes_ff == PASS_W'(1)) begin
                  rsp_valid_in  = 1'b1;
                  done_op_in    = hgba_pkg::FUNC_RUN;
                  cell_value_in = '0;
                  state_in      = ST_IDLE;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         slot_ff      <= SLOT_FIRST;
         base_ff      <= '0;
         passes_ff    <= '0;
         bank_ff      <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         slot_ff      <= slot_in;
         base_ff      <= base_in;
         passes_ff    <= passes_in;
         bank_ff      <= bank_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      done_op_ff    <= done_op_in;
      cell_value_ff <= cell_value_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_done_op    = done_op_ff;
   assign rsp_cell_value = cell_value_ff;

endmodule

// ===== rtl/heat_grid_box_average_unit.sv =====
`timescale 1ns / 1ps

// Grid of ROWS x COLS 14-bit temperatures with 3x3 box-mean (Jacobi) smoothing.
// A write transaction stores one cell and a read transaction returns one;
// cells outside the grid are ignored on write and read as zero. A run
// transaction performs pass_count passes; each pass walks the grid row by row
// with one read of the current bank's single read port per cycle, three reads
// per column of the sliding window, and then drains the divide pipeline.
// Passes alternate between two memory banks, so no copy-back is needed. After
// reset the block clears the grid before it accepts its first transaction;
// register writes are taken at any time.
module heat_grid_box_average_unit #(
   parameter int ROWS = hgba_pkg::ROWS_DEFAULT,
   parameter int COLS = hgba_pkg::COLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [hgba_pkg::FUNC_W-1:0]         req_func,
   input  logic [hgba_pkg::IDX_W-1:0]          req_row,
   input  logic [hgba_pkg::IDX_W-1:0]          req_col,
   input  logic [hgba_pkg::VAL_W-1:0]          req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [hgba_pkg::FUNC_W-1:0]         rsp_done_op,
   output logic [hgba_pkg::VAL_W-1:0]          rsp_cell_value,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hgba_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [hgba_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hgba_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int ADDR_W = $clog2(ROWS * COLS);

   logic [hgba_pkg::PASS_W-1:0] pass_count_ff, pass_count_in;
   logic                        csr_write;

   hgba_pkg::cmd_type           cmd;
   hgba_pkg::status_type        status;
   logic [ADDR_W-1:0]           rd_addr;
   logic [ADDR_W-1:0]           host_waddr;
   logic [hgba_pkg::VAL_W-1:0]  host_wdata;
   logic [ADDR_W-1:0]           pass_waddr;
   logic [hgba_pkg::VAL_W-1:0]  rd_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr == hgba_pkg::CSR_PASS_COUNT);

   always_comb begin
      pass_count_in = pass_count_ff;
      if (csr_write) begin
         pass_count_in = csr_pwdata[hgba_pkg::PASS_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr == hgba_pkg::CSR_PASS_COUNT) begin
         csr_prdata = hgba_pkg::CSR_DATA_W'(pass_count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_count_ff <= hgba_pkg::PASS_RESET;
      end else begin
         pass_count_ff <= pass_count_in;
      end
   end

   hgba_controller #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_done_op    (rsp_done_op),
      .rsp_cell_value (rsp_cell_value),
      .pass_count     (pass_count_ff),
      .cmd            (cmd),
      .rd_addr        (rd_addr),
      .host_waddr     (host_waddr),
      .host_wdata     (host_wdata),
      .pass_waddr     (pass_waddr),
      .rd_data        (rd_data),
      .status         (status)
   );

   hgba_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .host_waddr (host_waddr),
      .host_wdata (host_wdata),
      .pass_waddr (pass_waddr),
      .rd_data    (rd_data),
      .status     (status)
   );

endmodule

// ===== verif/heat_grid_box_average_unit_tb.sv =====
`timescale 1ns / 1ps

module heat_grid_box_average_unit_tb;

   localparam int FUNC_W     = hgba_pkg::FUNC_W;
   localparam int IDX_W      = hgba_pkg::IDX_W;
   localparam int VAL_W      = hgba_pkg::VAL_W;
   localparam int PASS_W     = hgba_pkg::PASS_W;
   localparam int CSR_ADDR_W = hgba_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = hgba_pkg::CSR_DATA_W;

   localparam int GRID_ROWS = hgba_pkg::ROWS_DEFAULT;
   localparam int GRID_COLS = hgba_pkg::COLS_DEFAULT;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [VAL_W-1:0]  TEMP_MAX    = 14'h3FFF;

   typedef struct packed {
      logic [FUNC_W-1:0] done_op;
      logic [VAL_W-1:0]  cell_value;
   } cell_reply_type;

   // Mirror of the temperature grid and of the pass count register, with the
   // replies still owed by the block in order of their requests.
   class grid_mirror_type;
      logic [VAL_W-1:0]  cells [GRID_ROWS][GRID_COLS];
      logic [PASS_W-1:0] passes;
      cell_reply_type    pending [$];
      int unsigned       error_count;

      function new();
         foreach (cells[r, c]) cells[r][c] = '0;
         passes      = hgba_pkg::PASS_RESET;
         error_count = 0;
      endfunction

      function void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
         error_count++;
         if (error_count <= 10)
            $display("mismatch in %s: expected %0h, got %0h at %0t",
                     what, want, got, $realtime);
      endfunction

      // One Jacobi pass: the truncated mean of the 3x3 box, with zero outside
      // the grid and the divisor fixed at nine even at the borders.
      function void smooth_once();
         logic [VAL_W-1:0] fresh [GRID_ROWS][GRID_COLS];
         int unsigned      sum;
         int               nr;
         int               nc;
         for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
               sum = 0;
               for (int dr = -1; dr <= 1; dr++) begin
                  for (int dc = -1; dc <= 1; dc++) begin
                     nr = r + dr;
                     nc = c + dc;
                     if (nr >= 0 && nr < GRID_ROWS && nc >= 0 && nc < GRID_COLS)
                        sum += cells[nr][nc];
                  end
               end
               fresh[r][c] = VAL_W'(sum / 9);
            end
         end
         cells = fresh;
      endfunction

      function void apply_request(logic [FUNC_W-1:0] func, logic [IDX_W-1:0] row,
                                  logic [IDX_W-1:0] col, logic [VAL_W-1:0] value);
         cell_reply_type reply;
         bit             on_grid;
         on_grid          = (row < GRID_ROWS) && (col < GRID_COLS);
         reply.done_op    = func;
         reply.cell_value = '0;
         unique case (func)
            hgba_pkg::FUNC_WRITE: begin
               if (on_grid) cells[row][col] = value;
            end
            hgba_pkg::FUNC_RUN: begin
               repeat (passes) smooth_once();
            end
            hgba_pkg::FUNC_READ: begin
               if (on_grid) reply.cell_value = cells[row][col];
            end
            default: ;
         endcase
         pending.push_back(reply);
      endfunction

      function void compare_response(logic [FUNC_W-1:0] op, logic [VAL_W-1:0] value);
         cell_reply_type want;
         if (pending.size() == 0) begin
            report_mismatch("response with nothing outstanding, done_op", '0, 32'(op));
            return;
         end
         want = pending.pop_front();
         if (op !== want.done_op)
            report_mismatch("done_op", 32'(want.done_op), 32'(op));
         if (value !== want.cell_value)
            report_mismatch("cell_value", 32'(want.cell_value), 32'(value));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func;
   logic [IDX_W-1:0]      req_row;
   logic [IDX_W-1:0]      req_col;
   logic [VAL_W-1:0]      req_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [FUNC_W-1:0]     rsp_done_op;
   logic [VAL_W-1:0]      rsp_cell_value;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   grid_mirror_type sb = new();
   bit              calm = 1'b0;

   heat_grid_box_average_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_func       (req_func),
      .req_row        (req_row),
      .req_col        (req_col),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_done_op    (rsp_done_op),
      .rsp_cell_value (rsp_cell_value),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Valid is held high across back-to-back transactions and only lowered
   // when a gap is drawn, so it never falls and rises in the same step.
   task automatic send_item(input logic [FUNC_W-1:0] func, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [VAL_W-1:0] value);
      int unsigned hold;
      hold = calm ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
         req_valid <= 1'b0;
         repeat (hold) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= func;
      req_row   <= row;
      req_col   <= col;
      req_value <= value;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.apply_request(func, row, col, value);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [PASS_W-1:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= hgba_pkg::CSR_PASS_COUNT;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata[PASS_W-1:0] !== want)
         sb.report_mismatch("pass_count readback", 32'(want), 32'(csr_prdata[PASS_W-1:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Upper data bits carry noise, which the register must drop.
   task automatic program_pass_count(input logic [PASS_W-1:0] count);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= hgba_pkg::CSR_PASS_COUNT;
      csr_pwdata  <= ($urandom() & 32'hFFFF_FF00) | CSR_DATA_W'(count);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.passes   = count;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_read_check(count);
   endtask

   initial begin
      int unsigned       pick;
      logic [VAL_W-1:0]  temp;
      logic [PASS_W-1:0] phase_passes [4];
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_func    <= hgba_pkg::FUNC_WRITE;
      req_row     <= '0;
      req_col     <= '0;
      req_value   <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read_check(hgba_pkg::PASS_RESET);

      // Directed part: corners, full-scale and zero temperatures, a cell never
      // written, the unused operation code, and runs at the reset pass count,
      // at zero passes, at the largest count and at a single pass.
      send_item(hgba_pkg::FUNC_READ, 4'd0, 4'd0, '0);
      send_item(hgba_pkg::FUNC_WRITE, 4'd0, 4'd0, TEMP_MAX);
      send_item(hgba_pkg::FUNC_WRITE, 4'd15, 4'd15, TEMP_MAX);
      send_item(hgba_pkg::FUNC_WRITE, 4'd0, 4'd15, 14'h2AAA);
      send_item(hgba_pkg::FUNC_WRITE, 4'd15, 4'd0, 14'h1555);
      send_item(hgba_pkg::FUNC_WRITE, 4'd7, 4'd8, TEMP_MAX);
      send_item(hgba_pkg::FUNC_READ, 4'd0, 4'd0, TEMP_MAX);
      send_item(hgba_pkg::FUNC_READ, 4'd15, 4'd15, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd7, 4'd8, '0);
      send_item(FUNC_UNUSED, 4'd15, 4'd15, TEMP_MAX);
      send_item(hgba_pkg::FUNC_RUN, 4'd0, 4'd0, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd0, 4'd0, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd1, 4'd1, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd7, 4'd7, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd15, 4'd15, '0);
      drain_responses();
      program_pass_count(8'd0);
      send_item(hgba_pkg::FUNC_RUN, 4'd15, 4'd15, TEMP_MAX);
      send_item(hgba_pkg::FUNC_READ, 4'd0, 4'd0, '0);
      drain_responses();
      program_pass_count(8'd255);
      send_item(hgba_pkg::FUNC_WRITE, 4'd8, 4'd8, TEMP_MAX);
      send_item(hgba_pkg::FUNC_RUN, 4'd0, 4'd0, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd8, 4'd8, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd0, 4'd0, '0);
      drain_responses();
      program_pass_count(8'd1);
      send_item(hgba_pkg::FUNC_WRITE, 4'd3, 4'd3, TEMP_MAX);
      send_item(hgba_pkg::FUNC_RUN, 4'd0, 4'd0, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd2, 4'd2, '0);
      send_item(hgba_pkg::FUNC_READ, 4'd4, 4'd4, '0);

      // Random part: mostly writes and reads, with occasional runs, keeping
      // the grid refilled so that smoothing keeps producing non-zero cells.
      phase_passes[0] = 8'd1;
      phase_passes[1] = 8'd3;
      phase_passes[2] = PASS_W'($urandom_range(0, 4));
      phase_passes[3] = 8'd2;
      for (int phase = 0; phase < 4; phase++) begin
         drain_responses();
         program_pass_count(phase_passes[phase]);
         for (int n = 0; n < 293; n++) begin
            if (n % 64 == 0) calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 149) == 0) drain_responses();
            case ($urandom_range(0, 7))
               0:       temp = TEMP_MAX;
               1:       temp = '0;
               default: temp = VAL_W'($urandom_range(0, 16383));
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 55)
               send_item(hgba_pkg::FUNC_WRITE, IDX_W'($urandom()), IDX_W'($urandom()), temp);
            else if (pick < 91)
               send_item(hgba_pkg::FUNC_READ, IDX_W'($urandom()), IDX_W'($urandom()), temp);
            else if (pick < 95)
               send_item(hgba_pkg::FUNC_RUN, IDX_W'($urandom()), IDX_W'($urandom()), temp);
            else
               send_item(FUNC_UNUSED, IDX_W'($urandom()), IDX_W'($urandom()), temp);
         end
      end

      calm = 1'b0;
      drain_responses();
      repeat (20) @(posedge clock);
      if (sb.error_count == 0 && sb.pending.size() == 0) begin
         $display("PASS heat_grid_box_average_unit");
      end else begin
         $display("FAIL heat_grid_box_average_unit");
      end
      $finish;
   end

   // Result side: a fresh stall is drawn for every transaction.
   initial begin
      int unsigned hold;
      rsp_ready <= 1'b0;
      repeat (9) @(posedge clock);
      forever begin
         hold = calm ? 0 : $urandom_range(0, 8);
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1 || rsp_ready !== 1'b1);
         sb.compare_response(rsp_done_op, rsp_cell_value);
      end
   end

   initial begin
      #25_000_000;
      $display("FAIL heat_grid_box_average_unit");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/hgba_pkg.sv
rtl/hgba_ram.sv
rtl/hgba_datapath.sv
rtl/hgba_controller.sv
rtl/heat_grid_box_average_unit.sv
verif/heat_grid_box_average_unit_tb.sv
